// File: design/pbu_pkg.sv
package pbu_pkg;

  localparam logic [2:0] MODE_SOLID    = 3'd0;
  localparam logic [2:0] MODE_TRANSP   = 3'd1;
  localparam logic [2:0] MODE_ADD      = 3'd2;
  localparam logic [2:0] MODE_SUB      = 3'd3;
  localparam logic [2:0] MODE_INVERT   = 3'd4;
  localparam logic [2:0] MODE_DISSOLVE = 3'd5;

  localparam logic [1:0] FMT_555  = 2'd0;
  localparam logic [1:0] FMT_565  = 2'd1;
  localparam logic [1:0] FMT_888  = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_FORMAT = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;
  localparam logic [1:0] REG_KEY    = 2'd3;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Path chosen by the front end for one pixel.
  typedef enum logic [2:0] {
    PATH_DEST,
    PATH_SRC,
    PATH_XOR,
    PATH_EXACT,
    PATH_CHAN
  } path_t;

  typedef struct packed {
    path_t       path;
    logic [2:0]  mode;
    logic [1:0]  fmt;
    logic [7:0]  alpha;
    logic [23:0] dest;
    logic [23:0] src;
    logic        kept;
  } work_t;

  function automatic logic [23:0] fmt_mask(input logic [1:0] f);
    unique case (f)
      FMT_555: fmt_mask = 24'h007fff;
      FMT_565: fmt_mask = 24'h00ffff;
      default: fmt_mask = 24'hffffff;
    endcase
  endfunction

endpackage

// File: design/pbu_front.sv
module pbu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_go,
  input  logic [23:0]         dest_pixel,
  input  logic [23:0]         src_pixel,
  output pbu_pkg::work_t      work
);
  import pbu_pkg::*;

  logic [2:0]  mode;
  logic [1:0]  fmt;
  logic [7:0]  alpha;
  logic [23:0] key;
  logic [15:0] lfsr;
  logic [15:0] lfsr_next;
  logic [23:0] d, s;
  logic        full;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_SOLID;
      fmt   <= FMT_888;
      alpha <= '0;
      key   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:   mode  <= cfg_data[2:0];
        REG_FORMAT: fmt   <= cfg_data[1:0];
        REG_ALPHA:  alpha <= cfg_data[7:0];
        REG_KEY:    key   <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign lfsr_next = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);

  always_ff @(posedge clk) begin
    if (rst) lfsr <= LFSR_SEED;
    else if (in_go && mode == MODE_DISSOLVE && fmt != FMT_NONE) lfsr <= lfsr_next;
  end

  always_comb begin
    d    = dest_pixel & fmt_mask(fmt);
    s    = src_pixel & fmt_mask(fmt);
    full = (alpha == 8'hff);
    work = '{path: PATH_CHAN, mode: mode, fmt: fmt, alpha: alpha,
             dest: d, src: s, kept: 1'b0};
    priority if (fmt == FMT_NONE || mode > MODE_DISSOLVE) begin
      work.path = PATH_DEST;
      work.dest = dest_pixel;
      work.kept = 1'b1;
    end else if (mode == MODE_SOLID) begin
      work.path = PATH_SRC;
    end else if (mode == MODE_DISSOLVE) begin
      work.kept = (lfsr_next[7:0] > alpha);
      work.path = work.kept ? PATH_DEST : PATH_SRC;
    end else if (mode == MODE_TRANSP && s == key) begin
      work.path = PATH_DEST;
      work.kept = 1'b1;
    end else if (full && mode == MODE_TRANSP) begin
      work.path = PATH_SRC;
    end else if (full && mode == MODE_INVERT) begin
      work.path = PATH_XOR;
    end else if (full && fmt != FMT_888) begin
      work.path = PATH_EXACT;
    end else begin
      work.path = PATH_CHAN;
    end
  end

endmodule

// File: design/pbu_queue.sv
module pbu_queue #(
  parameter int Depth = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pbu_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pbu_pkg::work_t pop_data
);
  import pbu_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t           slots [Depth];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;

  assign full     = (count == (AW+1)'(Depth));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count mismatch");

endmodule

// File: design/pbu_back.sv
module pbu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           have,
  input  pbu_pkg::work_t work,
  output logic           take,
  output logic           valid,
  input  logic           stall,
  output logic [23:0]    result_pixel,
  output logic           dest_kept
);
  import pbu_pkg::*;

  logic [4:0]  sh   [3];
  logic [3:0]  bits [3];
  logic [7:0]  dw   [3], sw [3], co [3];
  logic [7:0]  df   [3], sf [3], mx [3], ev [3];
  logic [15:0] sa   [3], ia [3];
  logic [8:0]  diff [3];
  logic [17:0] prod [3];
  logic [23:0] r_chan, r_exact, r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (work.fmt)
        FMT_555: begin sh[i] = 5'(10 - 5*i); bits[i] = 4'd5; end
        FMT_565: begin sh[i] = (i == 0) ? 5'd11 : ((i == 1) ? 5'd5 : 5'd0);
                       bits[i] = (i == 1) ? 4'd6 : 4'd5; end
        default: begin sh[i] = 5'(16 - 8*i); bits[i] = 4'd8; end
      endcase
      mx[i] = 8'((9'd1 << bits[i]) - 9'd1);
      df[i] = 8'(work.dest >> sh[i]) & mx[i];
      sf[i] = 8'(work.src >> sh[i]) & mx[i];
      dw[i] = 8'(df[i] << (4'd8 - bits[i]));
      sw[i] = 8'(sf[i] << (4'd8 - bits[i]));
      sa[i] = sw[i] * work.alpha;
      ia[i] = (sw[i] ^ 8'hff) * work.alpha;
      diff[i] = {1'b0, dw[i]} - {1'b0, sw[i]};
      prod[i] = $signed(diff[i]) * $signed({1'b0, work.alpha});
      unique case (work.mode)
        MODE_TRANSP: co[i] = 8'(($signed(prod[i]) +
                             ($signed(prod[i]) < 0 ? 18'sd255 : 18'sd0)) >>> 8) + sw[i];
        MODE_ADD:    co[i] = ({1'b0, dw[i]} + {1'b0, sa[i][15:8]} > 9'd255) ? 8'hff
                             : dw[i] + sa[i][15:8];
        MODE_SUB:    co[i] = (dw[i] > sa[i][15:8]) ? dw[i] - sa[i][15:8] : 8'd0;
        default:     co[i] = ia[i][15:8];
      endcase
      if (work.mode == MODE_ADD)
        ev[i] = ({1'b0, df[i]} + {1'b0, sf[i]} > {1'b0, mx[i]}) ? mx[i] : df[i] + sf[i];
      else
        ev[i] = (df[i] > sf[i]) ? df[i] - sf[i] : 8'd0;
    end
    r_chan  = '0;
    r_exact = '0;
    for (int i = 0; i < 3; i++) begin
      r_chan  = r_chan | (24'(co[i] >> (4'd8 - bits[i])) << sh[i]);
      r_exact = r_exact | (24'(ev[i]) << sh[i]);
    end
    unique case (work.path)
      PATH_DEST:  r = work.dest;
      PATH_SRC:   r = work.src;
      PATH_XOR:   r = work.src ^ fmt_mask(work.fmt);
      PATH_EXACT: r = r_exact;
      default:    r = r_chan;
    endcase
  end

  assign take = have && (!valid || !stall);

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (!valid || !stall) valid <= have;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_pixel <= (work.path == PATH_DEST) ? r : (r & fmt_mask(work.fmt));
      dest_kept    <= work.kept;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |=> valid && $stable(result_pixel))
    else $error("result changed while stalled");
  a_take: assert property (@(posedge clk) disable iff (rst) take |-> have)
    else $error("took from empty queue");

endmodule

// File: design/pixel_blend_unit.sv
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+--------------------------
// config    | in        | cfg_write           | cfg_index, cfg_data
// input     | in        | in_valid, in_stall  | dest_pixel, src_pixel
// output    | out       | out_valid, out_stall| result_pixel, dest_kept
//
// One pixel per clock is accepted and one result per clock delivered when
// the output is not stalled; each pixel passes the queue, then the result register.
// The front end classifies each pixel and advances the dissolve LFSR; the back
// end does the channel arithmetic. A two-entry queue between them lets input
// keep flowing while a result waits. Reset is synchronous and restores the
// configuration defaults, reseeds the LFSR, clears the queue and out_valid.
module pixel_blend_unit #(
  parameter int QueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] dest_pixel,
  input  logic [23:0] src_pixel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] result_pixel,
  output logic        dest_kept
);
  import pbu_pkg::*;

  work_t fwork, bwork;
  logic  q_full, q_empty, in_go, take;

  // Stall only when the queue is full; this depends on registered state alone.
  assign in_stall = q_full;
  assign in_go    = in_valid && !in_stall;

  pbu_front u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_go, .dest_pixel, .src_pixel, .work(fwork)
  );

  pbu_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .push(in_go), .push_data(fwork), .full(q_full),
    .pop(take), .empty(q_empty), .pop_data(bwork)
  );

  pbu_back u_back (
    .clk, .rst, .have(!q_empty), .work(bwork), .take,
    .valid(out_valid), .stall(out_stall), .result_pixel, .dest_kept
  );

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full)
    else $error("input stalled with room in queue");

endmodule
